/* src/slpl_pkg.sv */
// shared types, constants and arithmetic helpers for the stereo look-ahead peak limiter
// no dependencies; imported by every module of the block

package slpl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CEIL_W   = SAMPLE_W - 1;
    localparam int COEF_W   = 16;
    localparam int DLY_W    = 9;
    localparam int FRAC_W   = 16;
    localparam int ENV_W    = FRAC_W + 1;
    localparam int PROD_W   = SAMPLE_W + ENV_W;
    localparam int EPROD_W  = 2 * (ENV_W + 1);
    localparam int QCNT_W   = $clog2(FRAC_W);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QLVL_W   = $clog2(QDEPTH + 1);

    localparam logic [ENV_W-1:0]  ENV_UNITY   = ENV_W'(1) << FRAC_W;
    localparam int                ROUND_HALF  = 1 << (FRAC_W - 1);
    localparam logic [CEIL_W-1:0] CEIL_RESET  = CEIL_W'(7919357);
    localparam logic [COEF_W-1:0] COEF_RESET  = COEF_W'(64185);
    localparam logic [DLY_W-1:0]  DLY_RESET   = DLY_W'(479);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_CEILING = 2'd0;
    localparam logic [1:0] REG_ATTACK  = 2'd1;
    localparam logic [1:0] REG_DELAY   = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic [CEIL_W-1:0] ceiling_level;
        logic [COEF_W-1:0] attack_coefficient;
        logic [DLY_W-1:0]  lookahead_delay;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        peak;
        logic                       unity;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_job;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              full;
        logic              empty;
    } t_qstat;

    typedef struct packed {
        logic             busy;
        logic [ENV_W-1:0] env;
    } t_bstat;

    function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] u;
        u = s;
        return s[SAMPLE_W-1] ? (~u + SAMPLE_W'(1)) : u;
    endfunction

    function automatic logic [SAMPLE_W-1:0] scale_round(input logic [PROD_W-1:0] prod,
                                                        input logic neg);
        logic [PROD_W-1:0]   rounded;
        logic [SAMPLE_W-1:0] mag;
        rounded = (prod + PROD_W'(ROUND_HALF)) >> FRAC_W;
        mag     = rounded[SAMPLE_W-1:0];
        return neg ? (~mag + SAMPLE_W'(1)) : mag;
    endfunction

endpackage

/* src/slpl_queue.sv */
// two-entry job queue between the front and back parts of the limiter
// depends on slpl_pkg

module slpl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slpl_pkg::t_job i_push_data,
    input  logic           i_pop,
    output slpl_pkg::t_job o_head,
    output slpl_pkg::t_qstat o_stat
);
    import slpl_pkg::*;

    t_job              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;
    logic              do_push;
    logic              do_pop;

    assign do_push = i_push && (r_level != QLVL_W'(QDEPTH));
    assign do_pop  = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + QLVL_W'(1);
            end else if (do_pop && !do_push) begin
                r_level <= r_level - QLVL_W'(1);
            end
        end
    end

    assign o_head       = r_entry[r_rd_ptr];
    assign o_stat.level = r_level;
    assign o_stat.full  = (r_level == QLVL_W'(QDEPTH));
    assign o_stat.empty = (r_level == '0);

endmodule

/* src/slpl_front.sv */
// front part: takes sample pairs, finds the peak, runs the look-ahead delay line
// depends on slpl_pkg; feeds slpl_queue

module slpl_front #(
    parameter int DELAY_DEPTH = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  slpl_pkg::t_in_item i_in_data,
    input  slpl_pkg::t_cfg    i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output slpl_pkg::t_job    o_push_data
);
    import slpl_pkg::*;

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW = (AW > DLY_W) ? AW : DLY_W;
    localparam int LW = 2 * SAMPLE_W;

    logic [LW-1:0] r_mem [DELAY_DEPTH];
    logic [LW-1:0] r_rd_data;

    logic                       r_hold;
    logic [AW-1:0]              r_wp;
    logic [AW-1:0]              r_fill;
    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic [SAMPLE_W-1:0]        r_peak;
    logic                       r_bypass;
    logic                       r_live;

    logic                accept;
    logic [CW-1:0]       dly_ext;
    logic [AW-1:0]       d_eff;
    logic [AW:0]         wrap_sum;
    logic [AW-1:0]       rp;
    logic [AW-1:0]       n_wp;
    logic [SAMPLE_W-1:0] mag_l;
    logic [SAMPLE_W-1:0] mag_r;
    logic [SAMPLE_W-1:0] peak;

    assign accept     = i_in_valid && !r_hold;
    assign o_in_stall = r_hold;

    assign dly_ext  = CW'(i_cfg.lookahead_delay);
    assign d_eff    = (dly_ext > CW'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1) : dly_ext[AW-1:0];
    assign wrap_sum = {1'b0, r_wp} + (AW + 1)'(DELAY_DEPTH) - {1'b0, d_eff};
    assign rp       = (r_wp >= d_eff) ? (r_wp - d_eff) : wrap_sum[AW-1:0];
    assign n_wp     = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);

    assign mag_l = sample_mag(i_in_data.left_sample);
    assign mag_r = sample_mag(i_in_data.right_sample);
    assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wp] <= {i_in_data.left_sample, i_in_data.right_sample};
            r_rd_data   <= r_mem[rp];
            r_left      <= i_in_data.left_sample;
            r_right     <= i_in_data.right_sample;
            r_peak      <= peak;
            r_bypass    <= (d_eff == '0);
            r_live      <= (d_eff <= r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_wp   <= '0;
            r_fill <= '0;
        end else begin
            if (accept) begin
                r_hold <= 1'b1;
                r_wp   <= n_wp;
                if (r_fill != AW'(DELAY_DEPTH - 1)) begin
                    r_fill <= r_fill + AW'(1);
                end
            end else if (o_push) begin
                r_hold <= 1'b0;
            end
        end
    end

    assign o_push = r_hold && !i_q_full;

    always_comb begin
        o_push_data.peak  = r_peak;
        o_push_data.unity = (r_peak == '0) || ({1'b0, i_cfg.ceiling_level} >= r_peak);
        if (r_bypass) begin
            o_push_data.left_sample  = r_left;
            o_push_data.right_sample = r_right;
        end else if (r_live) begin
            o_push_data.left_sample  = r_rd_data[LW-1:SAMPLE_W];
            o_push_data.right_sample = r_rd_data[SAMPLE_W-1:0];
        end else begin
            o_push_data.left_sample  = '0;
            o_push_data.right_sample = '0;
        end
    end

endmodule

/* src/slpl_back.sv */
// back part: serial gain divider, envelope smoother and output scaling with result register
// depends on slpl_pkg; drains slpl_queue

module slpl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slpl_pkg::t_cfg     i_cfg,
    input  slpl_pkg::t_job     i_head,
    input  slpl_pkg::t_qstat   i_qstat,
    output logic               o_pop,
    output slpl_pkg::t_bstat   o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slpl_pkg::t_out_item o_out_data
);
    import slpl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ENV_MUL,
        ST_ENV_ADD,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN
    } t_state;

    t_state                     r_state;
    t_job                       r_job;
    logic [SAMPLE_W-1:0]        r_rem;
    logic [FRAC_W-1:0]          r_quo;
    logic [QCNT_W-1:0]          r_cnt;
    logic [ENV_W-1:0]           r_target;
    logic signed [EPROD_W-1:0]  r_eprod;
    logic [ENV_W-1:0]           r_env;
    logic [PROD_W-1:0]          r_prod;
    logic [SAMPLE_W-1:0]        r_left_out;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic [SAMPLE_W:0]          rem2;
    logic                       rem_ge;
    logic [SAMPLE_W:0]          rem_sub;
    logic [ENV_W-1:0]           k_coef;
    logic signed [ENV_W:0]      diff;
    logic signed [EPROD_W-1:0]  eprod_rnd;
    logic signed [EPROD_W-1:0]  eprod_shr;
    logic [ENV_W:0]             env_sum;
    logic                       out_free;

    assign rem2    = {r_rem, 1'b0};
    assign rem_ge  = rem2 >= {1'b0, r_job.peak};
    assign rem_sub = rem2 - {1'b0, r_job.peak};

    assign k_coef    = ENV_UNITY - ENV_W'(i_cfg.attack_coefficient);
    assign diff      = $signed({1'b0, r_target}) - $signed({1'b0, r_env});
    assign eprod_rnd = r_eprod + $signed(EPROD_W'(ROUND_HALF));
    assign eprod_shr = eprod_rnd >>> FRAC_W;
    assign env_sum   = eprod_shr[ENV_W:0] + {1'b0, r_env};

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_env       <= ENV_UNITY;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_job    <= i_head;
                        r_rem    <= SAMPLE_W'(i_cfg.ceiling_level);
                        r_quo    <= '0;
                        r_cnt    <= '0;
                        r_target <= ENV_UNITY;
                        r_state  <= i_head.unity ? ST_ENV_MUL : ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_ge ? rem_sub[SAMPLE_W-1:0] : rem2[SAMPLE_W-1:0];
                    r_quo <= {r_quo[FRAC_W-2:0], rem_ge};
                    r_cnt <= r_cnt + QCNT_W'(1);
                    if (r_cnt == QCNT_W'(FRAC_W - 1)) begin
                        r_target <= {1'b0, r_quo[FRAC_W-2:0], rem_ge};
                        r_state  <= ST_ENV_MUL;
                    end
                end
                ST_ENV_MUL: begin
                    r_eprod <= $signed({1'b0, k_coef}) * diff;
                    r_state <= ST_ENV_ADD;
                end
                ST_ENV_ADD: begin
                    r_env   <= env_sum[ENV_W-1:0];
                    r_state <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    r_prod  <= PROD_W'(sample_mag(r_job.left_sample)) * PROD_W'(r_env);
                    r_state <= ST_MUL_R;
                end
                ST_MUL_R: begin
                    r_left_out <= scale_round(r_prod, r_job.left_sample[SAMPLE_W-1]);
                    r_prod     <= PROD_W'(sample_mag(r_job.right_sample)) * PROD_W'(r_env);
                    r_state    <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_data.left_out  <= r_left_out;
                        r_out_data.right_out <= scale_round(r_prod,
                                                            r_job.right_sample[SAMPLE_W-1]);
                        r_out_valid          <= 1'b1;
                        r_state              <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.env  = r_env;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/stereo_lookahead_peak_limiter.sv */
// top level of the stereo look-ahead peak limiter: register port, front, queue and back
// depends on slpl_pkg, slpl_front, slpl_queue, slpl_back
//
//   channel   direction  handshake                    payload
//   in        sink       i_in_valid / o_in_stall      i_in_data (left_sample, right_sample)
//   out       source     o_out_valid / i_out_stall    o_out_data (left_out, right_out)
//   cfg       sink       psel, penable, pwrite        paddr, pwdata, prdata
//
// front holds each accepted pair until the queue takes it and takes no new pair meanwhile
// back skips the divider when the peak is at or under the ceiling and runs the
// 16-step serial gain divider otherwise; that divider sets the sustained rate
// synchronous active-low reset; the delay line needs no clearing, a fill count masks it
// a stalled output holds in its register while the front keeps filling the queue

module stereo_lookahead_peak_limiter #(
    parameter int DELAY_DEPTH = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  slpl_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output slpl_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slpl_pkg::APB_AW-1:0] paddr,
    input  logic [slpl_pkg::APB_DW-1:0] pwdata,
    output logic [slpl_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import slpl_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic   push;
    t_job   push_data;
    logic   pop;
    t_job   head;
    t_qstat qstat;
    t_bstat bstat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ceiling_level      <= CEIL_RESET;
            r_cfg.attack_coefficient <= COEF_RESET;
            r_cfg.lookahead_delay    <= DLY_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CEILING: r_cfg.ceiling_level      <= pwdata[CEIL_W-1:0];
                REG_ATTACK:  r_cfg.attack_coefficient <= pwdata[COEF_W-1:0];
                REG_DELAY:   r_cfg.lookahead_delay    <= pwdata[DLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CEILING: prdata = APB_DW'(r_cfg.ceiling_level);
            REG_ATTACK:  prdata = APB_DW'(r_cfg.attack_coefficient);
            REG_DELAY:   prdata = APB_DW'(r_cfg.lookahead_delay);
            default:     prdata = '0;
        endcase
    end

    slpl_front #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .i_q_full    (qstat.full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    slpl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (qstat)
    );

    slpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_stat      (bstat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_env_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.env <= ENV_UNITY)
        else $error("gain envelope above unity");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= QLVL_W'(QDEPTH))
        else $error("queue level out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty && !bstat.busy)
        else $error("pop while queue empty or back busy");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");
`endif

endmodule

/* bench/stereo_lookahead_peak_limiter_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for stereo_lookahead_peak_limiter: directed table, then random phases
// with an in-bench gain and delay-line predictor; depends on slpl_pkg and the limiter rtl

module stereo_lookahead_peak_limiter_tb;

    import slpl_pkg::*;

    localparam int LINE_DEPTH   = 512;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIR_ROWS     = 21;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        has_want;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        t_in_item    stim;
        t_out_item   want;
    } t_dir_row;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    t_in_item            in_data    = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    t_out_item           out_data;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // limiter state as predicted
    logic signed [SAMPLE_W-1:0] line_l [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] line_r [LINE_DEPTH];
    logic [DLY_W-1:0]           wr_pos;
    logic [ENV_W-1:0]           env_q16;
    logic [CEIL_W-1:0]          cfg_ceil;
    logic [COEF_W-1:0]          cfg_attack;
    logic [DLY_W-1:0]           cfg_delay;

    t_out_item expected_pairs [$];
    int        fail_count   = 0;
    int        cycle_count  = 0;
    bit        calm         = 1'b0;
    bit        hold_request = 1'b0;
    int        hold_left    = 0;

    t_dir_row dir_table [DIR_ROWS] = '{
        // fresh delay line at reset settings: zeros come out
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd8388607, 24'sd8388607}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'h800000, 24'h800000}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'h800000, 24'sd8388607}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd0, 24'sd0}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd1, -24'sd1}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd7919357, -24'sd7919358}, '{24'sd0, 24'sd0}},
        // zero delay, instant attack, full ceiling; upper bits dropped, unused index ignored
        '{ROW_WRITE, 1'b0, REG_DELAY, 32'hFFFF_FE00, '0, '0},
        '{ROW_WRITE, 1'b0, REG_ATTACK, 32'h0000_0000, '0, '0},
        '{ROW_WRITE, 1'b0, REG_CEILING, 32'hFFFF_FFFF, '0, '0},
        '{ROW_WRITE, 1'b0, REG_UNUSED, 32'h0000_0001, '0, '0},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd8388607, -24'sd8388607},
          '{24'sd8388607, -24'sd8388607}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd0, 24'sd0}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b0, REG_CEILING, 32'd0, '{24'h800000, 24'sd5}, '0},
        '{ROW_ITEM, 1'b0, REG_CEILING, 32'd0, '{-24'sd8388607, 24'sd8388607}, '0},
        // zero ceiling with instant attack mutes everything
        '{ROW_WRITE, 1'b0, REG_CEILING, 32'h0000_0000, '0, '0},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd1234567, -24'sd7654321}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd8388607, 24'sd1}, '{24'sd0, 24'sd0}},
        '{ROW_ITEM, 1'b1, REG_CEILING, 32'd0, '{24'sd0, 24'sd0}, '{24'sd0, 24'sd0}},
        '{ROW_WRITE, 1'b0, REG_ATTACK, 32'hFFFF_FFFF, '0, '0},
        '{ROW_WRITE, 1'b0, REG_DELAY, 32'h0000_0005, '0, '0},
        '{ROW_ITEM, 1'b0, REG_CEILING, 32'd0, '{24'sd8388607, 24'h800000}, '0}
    };

    stereo_lookahead_peak_limiter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [SAMPLE_W-1:0] apply_gain(
        input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] mag;
        logic [63:0]         prod;
        mag  = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
        prod = (64'(mag) * 64'(env_q16) + 64'd32768) >> FRAC_W;
        return s[SAMPLE_W-1] ? -SAMPLE_W'(prod) : SAMPLE_W'(prod);
    endfunction

    function automatic t_out_item limit_pair(input t_in_item pkt);
        logic [SAMPLE_W-1:0] pl;
        logic [SAMPLE_W-1:0] pr;
        logic [SAMPLE_W-1:0] peak;
        logic [63:0]         target;
        logic [63:0]         acc;
        logic [DLY_W-1:0]    rd_pos;
        t_out_item           res;
        pl = pkt.left_sample[SAMPLE_W-1] ? SAMPLE_W'(-pkt.left_sample)
                                         : SAMPLE_W'(pkt.left_sample);
        pr = pkt.right_sample[SAMPLE_W-1] ? SAMPLE_W'(-pkt.right_sample)
                                          : SAMPLE_W'(pkt.right_sample);
        peak = (pl > pr) ? pl : pr;
        if (peak == '0 || SAMPLE_W'(cfg_ceil) >= peak) begin
            target = 64'd65536;
        end else begin
            target = (64'(cfg_ceil) << FRAC_W) / 64'(peak);
        end
        acc = 64'(cfg_attack) * 64'(env_q16) + (64'd65536 - 64'(cfg_attack)) * target
              + 64'd32768;
        env_q16 = ENV_W'(acc >> FRAC_W);
        line_l[wr_pos] = pkt.left_sample;
        line_r[wr_pos] = pkt.right_sample;
        rd_pos = wr_pos - cfg_delay;
        res.left_out  = apply_gain(line_l[rd_pos]);
        res.right_out = apply_gain(line_r[rd_pos]);
        wr_pos = wr_pos + 1'b1;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] v;
        int                  m;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    2: v = 24'h000000;
                    default: v = 24'h800001;
                endcase
            end
            1, 2: begin
                m = int'($urandom_range(0, 2000)) - 1000;
                v = SAMPLE_W'(m);
            end
            3: begin
                m = int'(cfg_ceil) + int'($urandom_range(0, 8)) - 4;
                v = SAMPLE_W'(m);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_pair(input t_in_item pkt, input bit typed, input t_out_item typed_want);
        t_out_item predicted;
        @(negedge i_clk);
        in_valid = 1'b1;
        in_data  = pkt;
        do @(posedge i_clk); while (in_stall);
        predicted = limit_pair(pkt);
        expected_pairs.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CEILING: cfg_ceil   = data[CEIL_W-1:0];
            REG_ATTACK:  cfg_attack = data[COEF_W-1:0];
            REG_DELAY:   cfg_delay  = data[DLY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic reg_read(input logic [1:0] idx, output logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] ceil_v, input logic [31:0] attack_v,
                                  input logic [31:0] delay_v);
        logic [1:0]  idx;
        logic [31:0] rd;
        logic [31:0] want;
        drain();
        reg_write(REG_CEILING, ceil_v);
        reg_write(REG_ATTACK, attack_v);
        reg_write(REG_DELAY, delay_v);
        reg_write(REG_UNUSED, $urandom);
        for (idx = REG_CEILING; idx <= REG_DELAY; idx++) begin
            reg_read(idx, rd);
            case (idx)
                REG_CEILING: want = 32'(cfg_ceil);
                REG_ATTACK:  want = 32'(cfg_attack);
                default:     want = 32'(cfg_delay);
            endcase
            if (rd !== want) begin
                $error("register %0d readback expected %0h got %0h", idx, want, rd);
                fail_count++;
            end
        end
    endtask

    initial begin : stimulus
        int       r;
        int       p;
        int       n;
        t_in_item pkt;
        for (r = 0; r < LINE_DEPTH; r++) begin
            line_l[r] = '0;
            line_r[r] = '0;
        end
        wr_pos     = '0;
        env_q16    = ENV_UNITY;
        cfg_ceil   = CEIL_RESET;
        cfg_attack = COEF_RESET;
        cfg_delay  = DLY_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_WRITE) begin
                drain();
                reg_write(dir_table[r].reg_idx, dir_table[r].wdata);
            end else begin
                send_pair(dir_table[r].stim, dir_table[r].has_want, dir_table[r].want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_settings($urandom, $urandom, $urandom_range(0, 15));
                1: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: apply_settings(32'd0, 32'd0, 32'd0);
                3: apply_settings($urandom, $urandom_range(60000, 65535), $urandom_range(1, 40));
                4: apply_settings($urandom, $urandom, $urandom_range(0, 60));
                default: apply_settings($urandom_range(7000000, 8388607), $urandom, $urandom);
            endcase
            calm = (p == 3);
            if (p == 4) begin
                hold_request = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                while (!calm && $urandom_range(0, 99) < 30) begin
                    @(negedge i_clk);
                    in_valid = 1'b0;
                end
                pkt.left_sample  = rand_sample();
                pkt.right_sample = rand_sample();
                send_pair(pkt, 1'b0, '0);
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && expected_pairs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // output stall: random, none in the calm phase, one long hold-off on request
    initial begin : out_side
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall    = 1'b1;
            end else begin
                out_stall = !calm && ($urandom_range(0, 99) < 30);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_pairs.size() == 0) begin
                $error("result with no request pending: %0d %0d",
                       out_data.left_out, out_data.right_out);
                fail_count++;
            end else begin
                want = expected_pairs.pop_front();
                if (out_data.left_out !== want.left_out) begin
                    $error("left_out expected %0d got %0d", want.left_out, out_data.left_out);
                    fail_count++;
                end
                if (out_data.right_out !== want.right_out) begin
                    $error("right_out expected %0d got %0d", want.right_out, out_data.right_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
src/slpl_pkg.sv
src/slpl_queue.sv
src/slpl_front.sv
src/slpl_back.sv
src/stereo_lookahead_peak_limiter.sv
bench/stereo_lookahead_peak_limiter_tb.sv
